[rtl/core/qte_pkg.sv]
// ---------------------------------------------------------------------------
// qte_pkg: shared types and constants for the quaternion to Euler unit
// Fixed-point formats, CORDIC angle table and the per-lane step functions.
// ---------------------------------------------------------------------------
package qte_pkg;

  localparam int unsigned XY_W       = 37;  // CORDIC x/y datapath
  localparam int unsigned Z_W        = 27;  // angle accumulator, 1/65536 degree
  localparam int unsigned TRIM_W     = 17;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned SQ_STEPS   = 31;  // one result bit per isqrt stage
  localparam int unsigned ATAN_LEN   = 24;
  localparam int unsigned FULL_CIRCLE = 46080;

  localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(5898240);
  localparam logic signed [Z_W-1:0] HALF_TURN    = Z_W'(11796480);

  // register indexes of the configuration port
  localparam logic [1:0] REG_YAW_TRIM   = 2'd0;
  localparam logic [1:0] REG_PITCH_TRIM = 2'd1;
  localparam logic [1:0] REG_ROLL_TRIM  = 2'd2;

  typedef logic signed [XY_W-1:0] cxy_t;
  typedef logic signed [Z_W-1:0]  cz_t;

  typedef struct packed {
    cxy_t x;
    cxy_t y;
    cz_t  z;
  } lane_t;

  // atan(2^-n) in degrees * 65536, rounded
  function automatic cz_t atan_entry(input int unsigned n);
    cz_t v;
    case (n)
      0:  v = Z_W'(2949120);
      1:  v = Z_W'(1740967);
      2:  v = Z_W'(919879);
      3:  v = Z_W'(466945);
      4:  v = Z_W'(234379);
      5:  v = Z_W'(117304);
      6:  v = Z_W'(58666);
      7:  v = Z_W'(29335);
      8:  v = Z_W'(14668);
      9:  v = Z_W'(7334);
      10: v = Z_W'(3667);
      11: v = Z_W'(1833);
      12: v = Z_W'(917);
      13: v = Z_W'(458);
      14: v = Z_W'(229);
      15: v = Z_W'(115);
      16: v = Z_W'(57);
      17: v = Z_W'(29);
      18: v = Z_W'(14);
      19: v = Z_W'(7);
      20: v = Z_W'(4);
      21: v = Z_W'(2);
      22: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Axis cases resolve directly; they leave y at zero so no rotation follows.
  function automatic lane_t cordic_prep(input cxy_t y, input cxy_t x);
    lane_t l;
    l.x = x;
    l.y = y;
    l.z = '0;
    if (x == '0) begin
      l.x = XY_W'(1);
      l.y = '0;
      l.z = (y > 0) ? QUARTER_TURN : ((y < 0) ? -QUARTER_TURN : '0);
    end else if (y == '0) begin
      l.x = XY_W'(1);
      l.z = (x > 0) ? cz_t'(0) : HALF_TURN;
    end else if (x < 0) begin
      if (y > 0) begin
        l.x = y;
        l.y = -x;
        l.z = QUARTER_TURN;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -QUARTER_TURN;
      end
    end
    return l;
  endfunction

  function automatic lane_t cordic_iter(input lane_t l, input int unsigned n);
    lane_t o;
    cxy_t  xs;
    cxy_t  ys;
    o  = l;
    xs = l.x >>> n;
    ys = l.y >>> n;
    if (l.y > 0) begin
      o.x = l.x + ys;
      o.y = l.y - xs;
      o.z = l.z + atan_entry(n);
    end else if (l.y < 0) begin
      o.x = l.x - ys;
      o.y = l.y + xs;
      o.z = l.z - atan_entry(n);
    end
    return o;
  endfunction

  // round to 1/128 degree, add trim, wrap into [0, 360)
  function automatic logic [ANGLE_W-1:0] finish_angle(input cz_t z,
                                                      input logic signed [TRIM_W-1:0] trim);
    logic signed [Z_W:0] zr;
    logic signed [19:0]  v;
    logic signed [19:0]  w;
    zr = (Z_W+1)'(z) + (Z_W+1)'(256);
    v  = 20'(zr >>> 9) + 20'(trim);
    if (v < -20'sd46080)      w = v + 20'sd92160;
    else if (v < 0)           w = v + 20'sd46080;
    else if (v >= 20'sd46080) w = v - 20'sd46080;
    else                      w = v;
    return w[ANGLE_W-1:0];
  endfunction

endpackage

[rtl/core/quaternion_to_euler_degrees_unit.sv]
// ---------------------------------------------------------------------------
// quaternion_to_euler_degrees_unit: Z-Y-X Euler angles from a Q2.14 quaternion
// Pipelined products, isqrt and three CORDIC arctangent lanes, with trims.
// ---------------------------------------------------------------------------
// Channel  Direction  tdata / fields (low bit up)
// in_      slave      quat_real, quat_i, quat_j, quat_k (16 b signed each)
// out_     master     yaw_angle, pitch_angle, roll_angle (16 b unsigned each)
// cfg_     write      index 0 yaw_trim, 1 pitch_trim, 2 roll_trim (17 b signed)
//
// One transaction per cycle in and out while the output is taken. The
// pipeline has 3 arithmetic stages, 31 isqrt stages, CORDIC prep, one stage
// per micro-rotation, and the output register loaded through the wrap logic.
// The whole pipeline advances together; it holds when the output register is
// full and not taken. Reset clears valid bits and trims.
// ---------------------------------------------------------------------------
module quaternion_to_euler_degrees_unit #(
  parameter int unsigned ANGLE_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_real, quat_i, quat_j, quat_k
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // yaw_angle, pitch_angle, roll_angle
);

  localparam int unsigned SQ = qte_pkg::SQ_STEPS;
  localparam int unsigned NI = ANGLE_ITERATIONS;

  logic ce;
  logic signed [qte_pkg::TRIM_W-1:0] yaw_trim_r, pitch_trim_r, roll_trim_r;
  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;

  assign ce         = ~out_tvalid_r | out_tready;
  assign in_tready  = ce;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_trim_r   <= '0;
      pitch_trim_r <= '0;
      roll_trim_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        qte_pkg::REG_YAW_TRIM:   yaw_trim_r   <= cfg_wdata;
        qte_pkg::REG_PITCH_TRIM: pitch_trim_r <= cfg_wdata;
        qte_pkg::REG_ROLL_TRIM:  roll_trim_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- stage 1: component products
  logic signed [15:0] qr, qi, qj, qk;
  assign qr = in_tdata[15:0];
  assign qi = in_tdata[31:16];
  assign qj = in_tdata[47:32];
  assign qk = in_tdata[63:48];

  logic p1_vld_r;
  logic signed [31:0] rr_r, ii_r, jj_r, kk_r, ij_r, kr_r, jk_r, ir_r, jr_r, ik_r;

  always_ff @(posedge clk) begin
    if (!rst_n)  p1_vld_r <= 1'b0;
    else if (ce) p1_vld_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rr_r <= qr * qr;  ii_r <= qi * qi;  jj_r <= qj * qj;  kk_r <= qk * qk;
      ij_r <= qi * qj;  kr_r <= qk * qr;  jk_r <= qj * qk;  ir_r <= qi * qr;
      jr_r <= qj * qr;  ik_r <= qi * qk;
    end
  end

  // ---- stage 2: atan2 arguments, pitch cross term and clamp
  logic signed [33:0] yy_nxt, yx_nxt, ry_nxt, rx_nxt, sum4;
  logic signed [32:0] h_raw, h_nxt;
  logic        [31:0] d_val, ah_raw, ah_c;

  always_comb begin
    yy_nxt = 34'(2) * (34'(ij_r) + 34'(kr_r));
    yx_nxt = 34'(ii_r) - 34'(jj_r) - 34'(kk_r) + 34'(rr_r);
    ry_nxt = 34'(2) * (34'(jk_r) + 34'(ir_r));
    rx_nxt = -34'(ii_r) - 34'(jj_r) + 34'(kk_r) + 34'(rr_r);
    sum4   = 34'(rr_r) + 34'(ii_r) + 34'(jj_r) + 34'(kk_r);
    d_val  = sum4[32:1];
    h_raw  = 33'(jr_r) - 33'(ik_r);
    ah_raw = h_raw[32] ? 32'(-h_raw) : 32'(h_raw);
    h_nxt  = h_raw;
    ah_c   = ah_raw;
    if (ah_raw > d_val) begin
      ah_c  = d_val;
      h_nxt = h_raw[32] ? -33'(d_val) : 33'(d_val);
    end
  end

  logic p2_vld_r;
  logic signed [33:0] p2_yy_r, p2_yx_r, p2_ry_r, p2_rx_r;
  logic signed [32:0] p2_h_r;
  logic        [31:0] p2_lo_r;
  logic        [32:0] p2_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n)  p2_vld_r <= 1'b0;
    else if (ce) p2_vld_r <= p1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p2_yy_r <= yy_nxt;  p2_yx_r <= yx_nxt;
      p2_ry_r <= ry_nxt;  p2_rx_r <= rx_nxt;
      p2_h_r  <= h_nxt;
      p2_lo_r <= d_val - ah_c;
      p2_hi_r <= 33'(d_val) + 33'(ah_c);
    end
  end

  // ---- stage 3 and isqrt: (d-|h|)(d+|h|), then one root bit per stage
  logic               sq_vld_r [0:SQ];
  logic        [63:0] sq_rem_r [0:SQ];
  logic        [63:0] sq_res_r [0:SQ];
  logic signed [33:0] dl_yy_r  [0:SQ];
  logic signed [33:0] dl_yx_r  [0:SQ];
  logic signed [33:0] dl_ry_r  [0:SQ];
  logic signed [33:0] dl_rx_r  [0:SQ];
  logic signed [32:0] dl_h_r   [0:SQ];

  always_ff @(posedge clk) begin
    if (!rst_n)  sq_vld_r[0] <= 1'b0;
    else if (ce) sq_vld_r[0] <= p2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sq_rem_r[0] <= 64'(p2_lo_r * p2_hi_r);
      sq_res_r[0] <= '0;
      dl_yy_r[0]  <= p2_yy_r;  dl_yx_r[0] <= p2_yx_r;
      dl_ry_r[0]  <= p2_ry_r;  dl_rx_r[0] <= p2_rx_r;
      dl_h_r[0]   <= p2_h_r;
    end
  end

  for (genvar s = 0; s < SQ; s++) begin : g_sqrt
    localparam logic [63:0] SQ_BIT = 64'd1 << (2 * (SQ - 1 - s));
    logic [63:0] trial, rem_nxt, res_nxt;

    always_comb begin
      trial = sq_res_r[s] + SQ_BIT;
      if (sq_rem_r[s] >= trial) begin
        rem_nxt = sq_rem_r[s] - trial;
        res_nxt = (sq_res_r[s] >> 1) + SQ_BIT;
      end else begin
        rem_nxt = sq_rem_r[s];
        res_nxt = sq_res_r[s] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n)  sq_vld_r[s+1] <= 1'b0;
      else if (ce) sq_vld_r[s+1] <= sq_vld_r[s];
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        sq_rem_r[s+1] <= rem_nxt;
        sq_res_r[s+1] <= res_nxt;
        dl_yy_r[s+1]  <= dl_yy_r[s];  dl_yx_r[s+1] <= dl_yx_r[s];
        dl_ry_r[s+1]  <= dl_ry_r[s];  dl_rx_r[s+1] <= dl_rx_r[s];
        dl_h_r[s+1]   <= dl_h_r[s];
      end
    end
  end

  // ---- CORDIC: lane 0 yaw, lane 1 pitch, lane 2 roll
  logic            cv_r [0:NI];
  qte_pkg::lane_t  cl_r [0:NI][0:2];

  always_ff @(posedge clk) begin
    if (!rst_n)  cv_r[0] <= 1'b0;
    else if (ce) cv_r[0] <= sq_vld_r[SQ];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cl_r[0][0] <= qte_pkg::cordic_prep(qte_pkg::XY_W'(dl_yy_r[SQ]),
                                         qte_pkg::XY_W'(dl_yx_r[SQ]));
      cl_r[0][1] <= qte_pkg::cordic_prep(qte_pkg::XY_W'(dl_h_r[SQ]),
                                         qte_pkg::XY_W'({1'b0, sq_res_r[SQ][31:0]}));
      cl_r[0][2] <= qte_pkg::cordic_prep(qte_pkg::XY_W'(dl_ry_r[SQ]),
                                         qte_pkg::XY_W'(dl_rx_r[SQ]));
    end
  end

  for (genvar n = 0; n < NI; n++) begin : g_rot
    always_ff @(posedge clk) begin
      if (!rst_n)  cv_r[n+1] <= 1'b0;
      else if (ce) cv_r[n+1] <= cv_r[n];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (ce) cl_r[n+1][l] <= qte_pkg::cordic_iter(cl_r[n][l], n);
      end
    end
  end

  // ---- round, trim, wrap into the output register
  always_ff @(posedge clk) begin
    if (!rst_n)  out_tvalid_r <= 1'b0;
    else if (ce) out_tvalid_r <= cv_r[NI];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_tdata_r <= {qte_pkg::finish_angle(cl_r[NI][2].z, roll_trim_r),
                      qte_pkg::finish_angle(cl_r[NI][1].z, pitch_trim_r),
                      qte_pkg::finish_angle(cl_r[NI][0].z, yaw_trim_r)};
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] < 16'd46080) && (out_tdata[31:16] < 16'd46080)
                   && (out_tdata[47:32] < 16'd46080))
    else $error("angle outside [0, 360)");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(p1_vld_r) && $stable(cv_r[0]))
    else $error("pipeline moved during stall");
`endif

endmodule
